>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the queue's RTL files.
// Depends on nothing; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check with an explicit clock and active-low reset.
`define PCMQ_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check on the usual clk and rst_n of the enclosing module.
`define PCMQ_ASSERT(lbl, prop, msg) \
    `PCMQ_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

>>> hw/rtl/pcmq_pkg.sv
// Types, codes and helper functions of the priority class match queue.
// Depends on nothing; used by the queue top, its cells, its selector and the testbench.
`default_nettype none

package pcmq_pkg;

    // Default depth of the queue and number of classes a mask take accepts.
    localparam int QUEUE_DEPTH = 16;
    localparam int CLASS_COUNT = 16;

    // Operation codes.
    localparam logic [2:0] KIND_PUSH       = 3'd0;
    localparam logic [2:0] KIND_TAKE_MASK  = 3'd1;
    localparam logic [2:0] KIND_TAKE_CLASS = 3'd2;
    localparam logic [2:0] KIND_PROMOTE    = 3'd3;
    localparam logic [2:0] KIND_PEEK       = 3'd4;

    // Status codes.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [1:0] STATUS_NOMATCH = 2'd2;
    localparam logic [1:0] STATUS_FULL    = 2'd3;

    // One stored entry.
    typedef struct packed {
        logic [15:0] id;
        logic [3:0]  cls;
        logic [7:0]  model;
        logic [2:0]  svc_time;
        logic        urgent;
    } pcmq_entry_t;

    // Request word.
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] entry_id;
        logic [3:0]  entry_class;
        logic [7:0]  entry_model;
        logic [2:0]  service_time;
        logic        urgent;
        logic [15:0] class_mask;
    } pcmq_req_t;

    // Response word.
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_id;
        logic [3:0]  out_class;
        logic [7:0]  out_model;
        logic [2:0]  out_time;
        logic        out_urgent;
        logic [4:0]  occupancy;
    } pcmq_rsp_t;

    // Control handed along the row of cells.
    typedef struct packed {
        logic      commit;
        pcmq_req_t op;
    } pcmq_cell_ctrl_t;

    // Control from the sequencer to the selector.
    typedef struct packed {
        logic capture;
        logic pick;
        logic take;
        logic peek;
    } pcmq_sel_ctrl_t;

    // True when an entry of class cls is accepted by a take.
    function automatic logic class_accepted(input logic [3:0]  cls,
                                            input logic        by_mask,
                                            input logic [15:0] mask,
                                            input logic [3:0]  want);
        logic result;
        if (by_mask)
        begin
            result = (int'(cls) < CLASS_COUNT) && mask[cls];
        end
        else
        begin
            result = (cls == want);
        end
        return result;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pcmq_stream_if.sv
// Valid/ready channel carrying one word of a given payload type.
// Depends on nothing; the payload types come from pcmq_pkg at instantiation.
`default_nettype none

interface pcmq_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

>>> hw/rtl/priority_class_match_queue_unit.sv
// Top level of the priority class match queue: sequencer, fill count and row of cells.
// Depends on pcmq_pkg, pcmq_stream_if, pcmq_cell, pcmq_select and assert_macros.svh.
//
//  Channel | Modport | Word type  | Accepted when
//  req     | sink    | pcmq_req_t | req.valid && req.ready
//  rsp     | source  | pcmq_rsp_t | rsp.valid && rsp.ready
//
// Each request passes in order through accept, match in every cell, priority pick of the
// oldest candidate, then commit into the row of cells together with the response load.
// A new request is taken in the cycle after a commit, even while the response waits.
// A commit stalls while the previous response has not been taken.
// Reset empties the queue at once; slot contents need no clearing.
`default_nettype none
`include "assert_macros.svh"

module priority_class_match_queue_unit #(
    parameter int QUEUE_DEPTH = pcmq_pkg::QUEUE_DEPTH
) (
    input wire logic   clk,
    input wire logic   rst_n,
    pcmq_stream_if.sink   req,
    pcmq_stream_if.source rsp
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_PICK,
        S_APPLY
    } state_t;

    state_t              state_reg;
    pcmq_pkg::pcmq_req_t op_reg;
    logic [CW-1:0]       fill_reg;
    logic [CW-1:0]       fill_next;
    logic                out_valid_reg;
    pcmq_pkg::pcmq_rsp_t rsp_reg;
    pcmq_pkg::pcmq_rsp_t rsp_next;
    logic                load;
    logic                accept;
    logic                is_take;

    pcmq_pkg::pcmq_cell_ctrl_t cell_ctrl;
    pcmq_pkg::pcmq_sel_ctrl_t  sel_ctrl;
    pcmq_pkg::pcmq_entry_t     entries [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]    hits;
    logic [QUEUE_DEPTH-1:0]    urgent_hits;
    logic [QUEUE_DEPTH-1:0]    shift;
    logic                      found;
    pcmq_pkg::pcmq_entry_t     picked;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign load      = (state_reg == S_APPLY) && (!out_valid_reg || rsp.ready);
    assign is_take   = (op_reg.kind == pcmq_pkg::KIND_TAKE_MASK) ||
                       (op_reg.kind == pcmq_pkg::KIND_TAKE_CLASS);

    // Control for the selector and the cells.
    assign sel_ctrl.capture = (state_reg == S_MATCH);
    assign sel_ctrl.pick    = (state_reg == S_PICK);
    assign sel_ctrl.take    = is_take;
    assign sel_ctrl.peek    = (op_reg.kind == pcmq_pkg::KIND_PEEK) && (fill_reg != '0);

    assign cell_ctrl.commit = load;
    assign cell_ctrl.op     = op_reg;

    // Row of cells; the last one feeds itself when it shifts.
    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        pcmq_pkg::pcmq_entry_t next_entry;
        if (g == QUEUE_DEPTH - 1)
        begin : g_last
            assign next_entry = entries[g];
        end
        else
        begin : g_mid
            assign next_entry = entries[g+1];
        end

        pcmq_cell #(
            .QUEUE_DEPTH (QUEUE_DEPTH),
            .INDEX       (g)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .fill       (fill_reg),
            .shift      (shift[g]),
            .next_entry (next_entry),
            .entry      (entries[g]),
            .hit        (hits[g]),
            .urgent_hit (urgent_hits[g])
        );
    end

    pcmq_select #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_select (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (sel_ctrl),
        .hits        (hits),
        .urgent_hits (urgent_hits),
        .entries     (entries),
        .shift       (shift),
        .found       (found),
        .picked      (picked)
    );

    // Response word and new fill count of the committing operation.
    always_comb
    begin
        rsp_next        = '0;
        fill_next       = fill_reg;
        rsp_next.status = pcmq_pkg::STATUS_OK;
        case (op_reg.kind)
            pcmq_pkg::KIND_PUSH:
            begin
                if (fill_reg == CW'(QUEUE_DEPTH))
                begin
                    rsp_next.status = pcmq_pkg::STATUS_FULL;
                end
                else
                begin
                    fill_next = fill_reg + CW'(1);
                end
            end
            pcmq_pkg::KIND_TAKE_MASK, pcmq_pkg::KIND_TAKE_CLASS:
            begin
                if (fill_reg == '0)
                begin
                    rsp_next.status = pcmq_pkg::STATUS_EMPTY;
                end
                else if (!found)
                begin
                    rsp_next.status = pcmq_pkg::STATUS_NOMATCH;
                end
                else
                begin
                    fill_next           = fill_reg - CW'(1);
                    rsp_next.out_id     = picked.id;
                    rsp_next.out_class  = picked.cls;
                    rsp_next.out_model  = picked.model;
                    rsp_next.out_time   = picked.svc_time;
                    rsp_next.out_urgent = picked.urgent;
                end
            end
            pcmq_pkg::KIND_PROMOTE:
            begin
                if (fill_reg == '0)
                begin
                    rsp_next.status = pcmq_pkg::STATUS_EMPTY;
                end
            end
            pcmq_pkg::KIND_PEEK:
            begin
                if (fill_reg == '0)
                begin
                    rsp_next.status = pcmq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    rsp_next.out_id     = picked.id;
                    rsp_next.out_class  = picked.cls;
                    rsp_next.out_model  = picked.model;
                    rsp_next.out_time   = picked.svc_time;
                    rsp_next.out_urgent = picked.urgent;
                end
            end
            default:
            begin
            end
        endcase
        rsp_next.occupancy = 5'(fill_next);
    end

    // Sequencer, fill count and response valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_MATCH;
                    end
                end
                S_MATCH:
                begin
                    state_reg <= S_PICK;
                end
                S_PICK:
                begin
                    state_reg <= S_APPLY;
                end
                S_APPLY:
                begin
                    if (load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (load)
            begin
                fill_reg      <= fill_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= req.payload;
        end
        if (load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = rsp_reg;

    `PCMQ_ASSERT(a_fill_bound, (fill_reg <= CW'(QUEUE_DEPTH)), "fill count above depth")
    `PCMQ_ASSERT(a_fill_on_load, (!$stable(fill_reg) |-> $past(load)), "fill moved without commit")

endmodule

`default_nettype wire

>>> hw/rtl/pcmq_cell.sv
// One slot of the queue: holds an entry, matches it and shifts it towards the head.
// Depends on pcmq_pkg.
`default_nettype none

module pcmq_cell #(
    parameter int QUEUE_DEPTH = pcmq_pkg::QUEUE_DEPTH,
    parameter int INDEX       = 0
) (
    input  wire logic                       clk,
    input  wire pcmq_pkg::pcmq_cell_ctrl_t  ctrl,
    input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0] fill,
    input  wire logic                       shift,
    input  wire pcmq_pkg::pcmq_entry_t      next_entry,
    output pcmq_pkg::pcmq_entry_t           entry,
    output logic                            hit,
    output logic                            urgent_hit
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    pcmq_pkg::pcmq_entry_t entry_reg;
    pcmq_pkg::pcmq_entry_t entry_next;
    logic                  occupied;
    logic                  is_take;

    assign occupied = (fill > CW'(INDEX));
    assign is_take  = (ctrl.op.kind == pcmq_pkg::KIND_TAKE_MASK) ||
                      (ctrl.op.kind == pcmq_pkg::KIND_TAKE_CLASS);

    // Match of the held entry against the pending take.
    assign hit = occupied && is_take &&
                 pcmq_pkg::class_accepted(entry_reg.cls,
                                          ctrl.op.kind == pcmq_pkg::KIND_TAKE_MASK,
                                          ctrl.op.class_mask, ctrl.op.entry_class);
    assign urgent_hit = hit && entry_reg.urgent;

    // Next content of the slot once the operation commits.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.commit)
        begin
            case (ctrl.op.kind)
                pcmq_pkg::KIND_PUSH:
                begin
                    if (fill == CW'(INDEX))
                    begin
                        entry_next.id       = ctrl.op.entry_id;
                        entry_next.cls      = ctrl.op.entry_class;
                        entry_next.model    = ctrl.op.entry_model;
                        entry_next.svc_time = ctrl.op.service_time;
                        entry_next.urgent   = ctrl.op.urgent;
                    end
                end
                pcmq_pkg::KIND_TAKE_MASK, pcmq_pkg::KIND_TAKE_CLASS:
                begin
                    if (shift)
                    begin
                        entry_next = next_entry;
                    end
                end
                pcmq_pkg::KIND_PROMOTE:
                begin
                    if (occupied && (entry_reg.id == ctrl.op.entry_id))
                    begin
                        entry_next.urgent = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Slot contents carry no reset; only slots below the fill count are read.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

>>> hw/rtl/pcmq_select.sv
// Picks the oldest matching slot, derives the shift mask and muxes out its entry.
// Depends on pcmq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pcmq_select #(
    parameter int QUEUE_DEPTH = pcmq_pkg::QUEUE_DEPTH
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire pcmq_pkg::pcmq_sel_ctrl_t  ctrl,
    input  wire logic [QUEUE_DEPTH-1:0]    hits,
    input  wire logic [QUEUE_DEPTH-1:0]    urgent_hits,
    input  wire pcmq_pkg::pcmq_entry_t     entries [QUEUE_DEPTH],
    output logic [QUEUE_DEPTH-1:0]         shift,
    output logic                           found,
    output pcmq_pkg::pcmq_entry_t          picked
);

    logic [QUEUE_DEPTH-1:0] sel_reg;
    logic [QUEUE_DEPTH-1:0] sel_next;
    logic [QUEUE_DEPTH-1:0] pick_reg;
    logic [QUEUE_DEPTH-1:0] pick_next;

    // Candidate set: urgent matches win over plain matches; a peek takes the head.
    always_comb
    begin
        sel_next = sel_reg;
        if (ctrl.capture)
        begin
            if (ctrl.take)
            begin
                sel_next = (|urgent_hits) ? urgent_hits : hits;
            end
            else if (ctrl.peek)
            begin
                sel_next = QUEUE_DEPTH'(1);
            end
            else
            begin
                sel_next = '0;
            end
        end
    end

    // Lowest set bit of the candidate set is the oldest one. The old pick is
    // dropped while a new candidate set is captured.
    always_comb
    begin
        pick_next = pick_reg;
        if (ctrl.capture)
        begin
            pick_next = '0;
        end
        else if (ctrl.pick)
        begin
            pick_next = sel_reg & (~sel_reg + QUEUE_DEPTH'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg  <= '0;
            pick_reg <= '0;
        end
        else
        begin
            sel_reg  <= sel_next;
            pick_reg <= pick_next;
        end
    end

    // Slots at and behind the picked one move one place towards the head.
    assign shift = ~(pick_reg - QUEUE_DEPTH'(1));
    assign found = |pick_reg;

    // And-or mux of the picked entry.
    always_comb
    begin
        picked = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            picked = picked | (entries[i] & {$bits(pcmq_pkg::pcmq_entry_t){pick_reg[i]}});
        end
    end

    `PCMQ_ASSERT(a_pick_onehot, $onehot0(pick_reg), "picked slot is not one-hot")
    `PCMQ_ASSERT(a_pick_in_sel, ((pick_reg & ~sel_reg) == '0), "picked slot not a candidate")

endmodule

`default_nettype wire

>>> sim/pcmq_response_checker.sv
`timescale 1ns / 100ps
// Response checker for the priority class match queue: predicts every response word
// from the accepted request words and compares it with the word the block returns.
// Depends on pcmq_pkg for the word types, operation codes and status codes.

module pcmq_response_checker
    import pcmq_pkg::*;
#(
    parameter int DEPTH = pcmq_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  pcmq_req_t   req_word,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  pcmq_rsp_t   rsp_word,
    output int unsigned fault_count,
    output int unsigned awaited_count
);

    // Shadow copy of the waiting line; index 0 is the head.
    pcmq_entry_t waiting_line [DEPTH];
    int unsigned waiting_fill = 0;

    // Responses predicted for accepted requests, oldest first.
    pcmq_rsp_t   awaited_responses [$];
    pcmq_rsp_t   oldest_awaited;
    int unsigned fault_tally = 0;

    // True when a take of this request accepts an entry of class cls.
    function automatic bit class_wanted(input logic [3:0] cls, input pcmq_req_t rq);
        bit hit;
        if (rq.kind == KIND_TAKE_MASK)
        begin
            hit = (int'(cls) < CLASS_COUNT) && (rq.class_mask[cls] == 1'b1);
        end
        else
        begin
            hit = (cls == rq.entry_class);
        end
        return hit;
    endfunction

    // Applies one request to the shadow line and returns the response it causes.
    function automatic pcmq_rsp_t predict_response(input pcmq_req_t rq);
        pcmq_rsp_t   r;
        int          pick;
        pcmq_entry_t chosen;
        r    = '0;
        pick = -1;
        case (rq.kind)
            KIND_PUSH:
            begin
                if (waiting_fill >= DEPTH)
                begin
                    r.status = STATUS_FULL;
                end
                else
                begin
                    waiting_line[waiting_fill].id       = rq.entry_id;
                    waiting_line[waiting_fill].cls      = rq.entry_class;
                    waiting_line[waiting_fill].model    = rq.entry_model;
                    waiting_line[waiting_fill].svc_time = rq.service_time;
                    waiting_line[waiting_fill].urgent   = rq.urgent;
                    waiting_fill++;
                end
            end
            KIND_TAKE_MASK, KIND_TAKE_CLASS:
            begin
                if (waiting_fill == 0)
                begin
                    r.status = STATUS_EMPTY;
                end
                else
                begin
                    // Oldest urgent candidate first, then the oldest candidate of any kind.
                    for (int i = 0; i < waiting_fill; i++)
                    begin
                        if (pick < 0 && waiting_line[i].urgent
                            && class_wanted(waiting_line[i].cls, rq))
                        begin
                            pick = i;
                        end
                    end
                    for (int i = 0; i < waiting_fill; i++)
                    begin
                        if (pick < 0 && class_wanted(waiting_line[i].cls, rq))
                        begin
                            pick = i;
                        end
                    end
                    if (pick < 0)
                    begin
                        r.status = STATUS_NOMATCH;
                    end
                    else
                    begin
                        chosen       = waiting_line[pick];
                        r.out_id     = chosen.id;
                        r.out_class  = chosen.cls;
                        r.out_model  = chosen.model;
                        r.out_time   = chosen.svc_time;
                        r.out_urgent = chosen.urgent;
                        // Close the gap behind the removed entry.
                        for (int i = pick; i + 1 < waiting_fill; i++)
                        begin
                            waiting_line[i] = waiting_line[i + 1];
                        end
                        waiting_fill--;
                    end
                end
            end
            KIND_PROMOTE:
            begin
                if (waiting_fill == 0)
                begin
                    r.status = STATUS_EMPTY;
                end
                else
                begin
                    for (int i = 0; i < waiting_fill; i++)
                    begin
                        if (waiting_line[i].id == rq.entry_id)
                        begin
                            waiting_line[i].urgent = 1'b1;
                        end
                    end
                end
            end
            KIND_PEEK:
            begin
                if (waiting_fill == 0)
                begin
                    r.status = STATUS_EMPTY;
                end
                else
                begin
                    r.out_id     = waiting_line[0].id;
                    r.out_class  = waiting_line[0].cls;
                    r.out_model  = waiting_line[0].model;
                    r.out_time   = waiting_line[0].svc_time;
                    r.out_urgent = waiting_line[0].urgent;
                end
            end
            default:
            begin
            end
        endcase
        r.occupancy = 5'(waiting_fill);
        return r;
    endfunction

    // Reports one field that differs from its prediction; unknown bits count as a mismatch.
    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_tally++;
        end
    endtask

    // Sample both channels at each edge: responses are checked before the request
    // accepted at the same edge is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waiting_fill = 0;
            awaited_responses.delete();
            awaited_count <= 0;
            fault_count   <= fault_tally;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (awaited_responses.size() == 0)
                begin
                    $error("response word with no prediction waiting");
                    fault_tally++;
                end
                else
                begin
                    oldest_awaited = awaited_responses.pop_front();
                    compare_field("status", oldest_awaited.status, rsp_word.status);
                    compare_field("out_id", oldest_awaited.out_id, rsp_word.out_id);
                    compare_field("out_class", oldest_awaited.out_class, rsp_word.out_class);
                    compare_field("out_model", oldest_awaited.out_model, rsp_word.out_model);
                    compare_field("out_time", oldest_awaited.out_time, rsp_word.out_time);
                    compare_field("out_urgent", oldest_awaited.out_urgent,
                                  rsp_word.out_urgent);
                    compare_field("occupancy", oldest_awaited.occupancy, rsp_word.occupancy);
                end
            end
            if (req_valid && req_ready)
            begin
                awaited_responses.push_back(predict_response(req_word));
            end
            awaited_count <= awaited_responses.size();
            fault_count   <= fault_tally;
        end
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Top of the queue testbench: clock, reset, request words and response back-pressure.
// Depends on pcmq_pkg, pcmq_stream_if, the queue RTL and pcmq_response_checker.

module testbench;

    import pcmq_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int          RANDOM_WORDS  = 1700;
    localparam int          IDLE_PERCENT  = 33;
    localparam int          TIDE_LENGTH   = 48;
    localparam int          DRAIN_CYCLES  = 16;
    localparam logic [2:0]  KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  KIND_SPARE_LAST  = 3'd7;

    logic        clk;
    logic        rst_n;
    bit          calm;
    bit          filling;
    int unsigned cycle_count = 0;
    int unsigned fault_count;
    int unsigned awaited_count;
    logic [15:0] id_pool [8];

    pcmq_stream_if #(.payload_t(pcmq_req_t)) req_if ();
    pcmq_stream_if #(.payload_t(pcmq_rsp_t)) rsp_if ();

    priority_class_match_queue_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    pcmq_response_checker response_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_if.valid),
        .req_ready     (req_if.ready),
        .req_word      (req_if.payload),
        .rsp_valid     (rsp_if.valid),
        .rsp_ready     (rsp_if.ready),
        .rsp_word      (rsp_if.payload),
        .fault_count   (fault_count),
        .awaited_count (awaited_count)
    );

    // 10 ns clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog on the length of the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** priority_class_match_queue_unit: FAILED **");
            $finish;
        end
    end

    // Response back-pressure: stalls at random except during the calm stretch.
    initial
    begin
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Offers one request word, with random idle cycles first, and waits until it is taken.
    task automatic send_word(input pcmq_req_t w);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            req_if.valid   <= 1'b0;
            req_if.payload <= pcmq_req_t'($bits(pcmq_req_t)'({$urandom, $urandom}));
            @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= w;
        @(posedge clk);
        while (!req_if.ready)
        begin
            @(posedge clk);
        end
    endtask

    function automatic pcmq_req_t make_word(input logic [2:0] kind, input logic [15:0] id,
                                            input logic [3:0] cls, input logic [7:0] model,
                                            input logic [2:0] stime, input logic urg,
                                            input logic [15:0] mask);
        pcmq_req_t w;
        w.kind         = kind;
        w.entry_id     = id;
        w.entry_class  = cls;
        w.entry_model  = model;
        w.service_time = stime;
        w.urgent       = urg;
        w.class_mask   = mask;
        return w;
    endfunction

    // Picks an operation; a filling tide favours pushes, a draining tide favours takes.
    function automatic logic [2:0] random_kind(input bit fill_tide);
        int unsigned roll;
        int unsigned rest;
        logic [2:0]  k;
        roll = $urandom_range(0, 99);
        rest = $urandom_range(0, 9);
        if (roll < 2)
        begin
            k = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
        end
        else if (roll < (fill_tide ? 87 : 17))
        begin
            k = KIND_PUSH;
        end
        else if (rest < 4)
        begin
            k = KIND_TAKE_MASK;
        end
        else if (rest < 7)
        begin
            k = KIND_TAKE_CLASS;
        end
        else if (rest < 9)
        begin
            k = KIND_PROMOTE;
        end
        else
        begin
            k = KIND_PEEK;
        end
        return k;
    endfunction

    // Random fields; ids mostly come from a small pool so that promotions find entries.
    function automatic pcmq_req_t random_word(input logic [2:0] kind, input bit fill_tide);
        logic [15:0] id;
        logic [3:0]  cls;
        logic [15:0] mask;
        id  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : id_pool[$urandom_range(0, 7)];
        cls = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3)) : 4'($urandom);
        case ($urandom_range(0, 3))
            0:       mask = 16'($urandom);
            1:       mask = 16'h0001 << $urandom_range(0, 15);
            2:       mask = fill_tide ? 16'h0000 : 16'hFFFF;
            default: mask = 16'($urandom) | 16'($urandom);
        endcase
        return make_word(kind, id, cls, 8'($urandom), 3'($urandom_range(2, 5)),
                         1'($urandom_range(0, 3) == 0), mask);
    endfunction

    // Stimulus: reset, directed words, then random words in filling and draining tides.
    initial
    begin
        rst_n          <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        calm    = 1'b0;
        filling = 1'b1;
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        for (int i = 2; i < 8; i++)
        begin
            id_pool[i] = 16'($urandom);
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every operation but a push on an empty queue, and an unused operation code.
        send_word(make_word(KIND_PEEK, 16'h0000, 4'd0, 8'h00, 3'd2, 1'b0, 16'hFFFF));
        send_word(make_word(KIND_TAKE_MASK, 16'h0000, 4'd0, 8'h00, 3'd2, 1'b0, 16'hFFFF));
        send_word(make_word(KIND_TAKE_CLASS, 16'h0000, 4'd0, 8'h00, 3'd2, 1'b0, 16'h0000));
        send_word(make_word(KIND_PROMOTE, 16'h0000, 4'd0, 8'h00, 3'd2, 1'b0, 16'h0000));
        send_word(make_word(KIND_SPARE_LAST, 16'hFFFF, 4'hF, 8'hFF, 3'd5, 1'b1, 16'hFFFF));

        // Entries at the extremes of their fields, and two sharing one id.
        send_word(make_word(KIND_PUSH, 16'hFFFF, 4'hF, 8'hFF, 3'd5, 1'b1, 16'h0000));
        send_word(make_word(KIND_PUSH, 16'h0000, 4'h0, 8'h00, 3'd2, 1'b0, 16'hFFFF));
        send_word(make_word(KIND_PUSH, 16'h1234, 4'h3, 8'h5A, 3'd3, 1'b0, 16'h0000));
        send_word(make_word(KIND_PUSH, 16'h1234, 4'h3, 8'hA5, 3'd4, 1'b0, 16'h0000));
        send_word(make_word(KIND_PEEK, 16'h0000, 4'd0, 8'h00, 3'd2, 1'b0, 16'h0000));

        // Takes that find nothing leave the queue alone.
        send_word(make_word(KIND_TAKE_MASK, 16'h0000, 4'd0, 8'h00, 3'd2, 1'b0, 16'h0000));
        send_word(make_word(KIND_TAKE_CLASS, 16'h0000, 4'd9, 8'h00, 3'd2, 1'b0, 16'hFFFF));

        // Promotion of a shared id, and of an id that is not waiting.
        send_word(make_word(KIND_PROMOTE, 16'h1234, 4'd0, 8'h00, 3'd2, 1'b0, 16'h0000));
        send_word(make_word(KIND_PROMOTE, 16'h7777, 4'd0, 8'h00, 3'd2, 1'b0, 16'h0000));

        // An urgent entry wins over an older ordinary one; then the head; then by class.
        send_word(make_word(KIND_TAKE_MASK, 16'h0000, 4'd0, 8'h00, 3'd2, 1'b0, 16'h0009));
        send_word(make_word(KIND_TAKE_MASK, 16'h0000, 4'd0, 8'h00, 3'd2, 1'b0, 16'hFFFF));
        send_word(make_word(KIND_TAKE_CLASS, 16'h0000, 4'd0, 8'h00, 3'd2, 1'b0, 16'h0000));
        send_word(make_word(KIND_SPARE_FIRST, 16'h0000, 4'd0, 8'h00, 3'd2, 1'b0, 16'h0000));
        send_word(make_word(KIND_TAKE_CLASS, 16'h0000, 4'd3, 8'h00, 3'd2, 1'b0, 16'h0000));

        // Random words; the tides take the queue to full and back to empty many times.
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            filling = ((i / TIDE_LENGTH) % 2) == 0;
            calm    = (i >= 700) && (i < 1000);
            send_word(random_word(random_kind(filling), filling));
        end
        req_if.valid <= 1'b0;
        calm = 1'b0;

        // Let the last responses arrive, then allow the pipeline to settle.
        @(posedge clk);
        while (awaited_count != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0)
        begin
            $display("** priority_class_match_queue_unit: PASSED **");
        end
        else
        begin
            $display("** priority_class_match_queue_unit: FAILED **");
        end
        $finish;
    end

endmodule
